>>> design/phr_pkg.sv
// ----------------------------------------------------------------------------
// phr_pkg
// Shared types and command codes of the position history rewind block.
// ----------------------------------------------------------------------------
package phr_pkg;

   localparam logic [1:0] CMD_BEGIN  = 2'd0;
   localparam logic [1:0] CMD_RECORD = 2'd1;
   localparam logic [1:0] CMD_SAMPLE = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic [31:0]        tick_whole;
      logic [7:0]         tick_fraction;
      logic [5:0]         entity;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [31:0]        oldest_tick;
   } rsp_type;

   // One position as three lanes: lane 2 is x, lane 1 is y, lane 0 is z.
   typedef logic [2:0][31:0] pos_type;

endpackage

>>> design/phr_if.sv
// ----------------------------------------------------------------------------
// phr_if
// Valid/ready channels for the requests and responses of the block.
// ----------------------------------------------------------------------------
interface phr_req_if;
   logic              valid;
   logic              ready;
   phr_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface phr_rsp_if;
   logic              valid;
   logic              ready;
   phr_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> design/position_history_rewind.sv
// ----------------------------------------------------------------------------
// position_history_rewind
// Ring of timestamped frames holding entity positions, with interpolated
// lookback.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and answers each with exactly one
// response. Record and clear go straight from acceptance to the response
// state. A begin frame clears the entity marks of the reused frame one per
// cycle through the single write port of the cell memory and, once the ring
// is full, then reads the new oldest tick from the frame tick memory. A
// sample sweeps the frame tick memory one slot per cycle, then reads up to two
// cells in S_RD1, S_WT1, S_RD2 and S_WT2 and interpolates z, y and x in turn
// on the shared multiplier. No clearing pass is needed after reset; a frame's
// marks are cleared when it is opened.
module position_history_rewind #(
   parameter int HISTORY_DEPTH = 64,
   parameter int ENTITY_SLOTS  = 64
) (
   input logic        clock,
   input logic        reset,
   phr_req_if.sink    req_ch,
   phr_rsp_if.source  rsp_ch
);

   localparam int SW     = HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1;
   localparam int HW     = $clog2(HISTORY_DEPTH + 1);
   localparam int CELLS  = HISTORY_DEPTH * ENTITY_SLOTS;
   localparam int AW     = CELLS > 1 ? $clog2(CELLS) : 1;
   localparam int MAXHE  = HISTORY_DEPTH > ENTITY_SLOTS ? HISTORY_DEPTH : ENTITY_SLOTS;
   localparam int CW_RAW = $clog2(MAXHE + 1);
   localparam int CW     = CW_RAW < 2 ? 2 : CW_RAW;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FILL   = 4'd1;
   localparam logic [3:0] S_OLD_RD = 4'd2;
   localparam logic [3:0] S_OLD_WT = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_RD1    = 4'd5;
   localparam logic [3:0] S_WT1    = 4'd6;
   localparam logic [3:0] S_RD2    = 4'd7;
   localparam logic [3:0] S_WT2    = 4'd8;
   localparam logic [3:0] S_MUL    = 4'd9;
   localparam logic [3:0] S_RESP   = 4'd10;

   logic [3:0]              state_ff, state_in;
   phr_pkg::req_type        req_ff, req_in;
   phr_pkg::rsp_type        rsp_ff, rsp_in;
   logic [HISTORY_DEPTH-1:0] filled_ff, filled_in;
   logic [SW-1:0]           wslot_ff, wslot_in;
   logic [HW-1:0]           held_ff, held_in;
   logic [31:0]             latest_ff, latest_in;
   logic                    open_ff, open_in;
   logic [31:0]             oldest_ff, oldest_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [SW-1:0]           pslot_ff, pslot_in;
   logic                    pvalid_ff, pvalid_in;
   logic                    hit1_ff, hit1_in;
   logic                    hit2_ff, hit2_in;
   logic [SW-1:0]           slot1_ff, slot1_in;
   logic [SW-1:0]           slot2_ff, slot2_in;
   phr_pkg::pos_type        a_ff, a_in;
   phr_pkg::pos_type        b_ff, b_in;
   phr_pkg::pos_type        res_ff, res_in;
   logic signed [41:0]      prod_ff, prod_in;

   logic                    f_we;
   logic [SW-1:0]           f_waddr, f_raddr;
   logic [31:0]             f_wdata, f_rdata;
   logic                    c_we;
   logic [AW-1:0]           c_waddr, c_raddr;
   logic [96:0]             c_wdata, c_rdata;

   logic [SW-1:0]           prev_slot;
   logic                    ent_ok_new;
   logic [1:0]              lane;
   logic signed [32:0]      diff;
   logic [31:0]             step;
   logic [31:0]             tick_next;

   function automatic logic [AW-1:0] cell_addr(input logic [SW-1:0] s, input logic [31:0] e);
      return AW'(32'(s) * 32'(ENTITY_SLOTS) + e);
   endfunction

   function automatic phr_pkg::rsp_type make_rsp(input logic ok, input phr_pkg::pos_type p,
                                                 input logic [31:0] oldest);
      phr_pkg::rsp_type r;
      r.ok          = ok;
      r.out_x       = p[2];
      r.out_y       = p[1];
      r.out_z       = p[0];
      r.oldest_tick = oldest;
      return r;
   endfunction

   phr_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_frame_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_addr (f_raddr),
      .rd_data (f_rdata)
   );

   // Each cell word is the present mark followed by x, y and z.
   phr_ram #(.WIDTH(97), .DEPTH(CELLS)) u_cell_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_addr (c_raddr),
      .rd_data (c_rdata)
   );

   assign prev_slot  = (wslot_ff == '0) ? SW'(HISTORY_DEPTH - 1) : wslot_ff - SW'(1);
   assign ent_ok_new = 32'(req_ch.data.entity) < 32'(ENTITY_SLOTS);
   assign lane       = cnt_ff[1:0];
   assign tick_next  = req_ff.tick_whole + 32'd1;

   // Shared interpolation datapath: one lane per cycle.
   always_comb begin
      if (lane == 2'd3) begin
         diff = '0;
      end else begin
         diff = 33'($signed({b_ff[lane][31], b_ff[lane]}) - $signed({a_ff[lane][31], a_ff[lane]}));
      end
      step = prod_ff[39:8];
   end

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      filled_in = filled_ff;
      wslot_in  = wslot_ff;
      held_in   = held_ff;
      latest_in = latest_ff;
      open_in   = open_ff;
      oldest_in = oldest_ff;
      cnt_in    = cnt_ff;
      pslot_in  = pslot_ff;
      pvalid_in = pvalid_ff;
      hit1_in   = hit1_ff;
      hit2_in   = hit2_ff;
      slot1_in  = slot1_ff;
      slot2_in  = slot2_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      res_in    = res_ff;
      prod_in   = prod_ff;
      f_we      = 1'b0;
      f_waddr   = wslot_ff;
      f_wdata   = req_ch.data.tick_whole;
      f_raddr   = wslot_ff;
      c_we      = 1'b0;
      c_waddr   = cell_addr(slot1_ff, 32'(cnt_ff));
      c_wdata   = '0;
      c_raddr   = cell_addr(slot1_ff, 32'(req_ff.entity));

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               req_in   = req_ch.data;
               state_in = S_RESP;
               rsp_in   = make_rsp(1'b0, '0, oldest_ff);
               unique case (req_ch.data.command)
                  phr_pkg::CMD_BEGIN: begin
                     if (!(held_ff != '0 && req_ch.data.tick_whole <= latest_ff)) begin
                        f_we                = 1'b1;
                        filled_in[wslot_ff] = 1'b1;
                        latest_in           = req_ch.data.tick_whole;
                        open_in             = 1'b1;
                        if (held_ff == '0) begin
                           oldest_in = req_ch.data.tick_whole;
                        end
                        if (held_ff != HW'(HISTORY_DEPTH)) begin
                           held_in = held_ff + HW'(1);
                        end
                        wslot_in = (wslot_ff == SW'(HISTORY_DEPTH - 1)) ? '0 : wslot_ff + SW'(1);
                        slot1_in = wslot_ff;
                        cnt_in   = '0;
                        state_in = S_FILL;
                     end
                  end
                  phr_pkg::CMD_RECORD: begin
                     if (open_ff && ent_ok_new) begin
                        c_we    = 1'b1;
                        c_waddr = cell_addr(prev_slot, 32'(req_ch.data.entity));
                        c_wdata = {1'b1, req_ch.data.pos_x, req_ch.data.pos_y,
                                   req_ch.data.pos_z};
                        rsp_in  = make_rsp(1'b1, '0, oldest_ff);
                     end
                  end
                  phr_pkg::CMD_SAMPLE: begin
                     if (held_ff != '0 && req_ch.data.tick_whole <= latest_ff && ent_ok_new) begin
                        cnt_in    = '0;
                        pvalid_in = 1'b0;
                        hit1_in   = 1'b0;
                        hit2_in   = 1'b0;
                        state_in  = S_SCAN;
                     end
                  end
                  phr_pkg::CMD_CLEAR: begin
                     filled_in = '0;
                     wslot_in  = '0;
                     held_in   = '0;
                     latest_in = '0;
                     open_in   = 1'b0;
                     oldest_in = '0;
                     rsp_in    = make_rsp(1'b1, '0, 32'd0);
                  end
                  default: begin
                     rsp_in = make_rsp(1'b0, '0, oldest_ff);
                  end
               endcase
            end
         end
         S_FILL: begin
            // Clear the entity marks of the frame being reused.
            c_we   = 1'b1;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(ENTITY_SLOTS - 1)) begin
               if (held_ff == HW'(HISTORY_DEPTH)) begin
                  state_in = S_OLD_RD;
               end else begin
                  rsp_in   = make_rsp(1'b1, '0, oldest_ff);
                  state_in = S_RESP;
               end
            end
         end
         S_OLD_RD: begin
            // With the ring full, the next slot to be overwritten is the oldest.
            f_raddr  = wslot_ff;
            state_in = S_OLD_WT;
         end
         S_OLD_WT: begin
            oldest_in = f_rdata;
            rsp_in    = make_rsp(1'b1, '0, f_rdata);
            state_in  = S_RESP;
         end
         S_SCAN: begin
            f_raddr   = cnt_ff[SW-1:0];
            pvalid_in = cnt_ff < CW'(HISTORY_DEPTH);
            pslot_in  = cnt_ff[SW-1:0];
            cnt_in    = cnt_ff + CW'(1);
            if (pvalid_ff && filled_ff[pslot_ff]) begin
               if (f_rdata == req_ff.tick_whole) begin
                  hit1_in  = 1'b1;
                  slot1_in = pslot_ff;
               end
               if (req_ff.tick_whole != 32'hFFFF_FFFF && f_rdata == tick_next) begin
                  hit2_in  = 1'b1;
                  slot2_in = pslot_ff;
               end
            end
            if (cnt_ff == CW'(HISTORY_DEPTH)) begin
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            if (hit1_ff) begin
               state_in = S_WT1;
            end else begin
               rsp_in   = make_rsp(1'b0, '0, oldest_ff);
               state_in = S_RESP;
            end
         end
         S_WT1: begin
            a_in = c_rdata[95:0];
            if (!c_rdata[96]) begin
               rsp_in   = make_rsp(1'b0, '0, oldest_ff);
               state_in = S_RESP;
            end else if (req_ff.tick_fraction != 8'd0 && hit2_ff) begin
               state_in = S_RD2;
            end else begin
               rsp_in   = make_rsp(1'b1, c_rdata[95:0], oldest_ff);
               state_in = S_RESP;
            end
         end
         S_RD2: begin
            c_raddr  = cell_addr(slot2_ff, 32'(req_ff.entity));
            state_in = S_WT2;
         end
         S_WT2: begin
            if (c_rdata[96]) begin
               b_in     = c_rdata[95:0];
               cnt_in   = '0;
               state_in = S_MUL;
            end else begin
               rsp_in   = make_rsp(1'b1, a_ff, oldest_ff);
               state_in = S_RESP;
            end
         end
         S_MUL: begin
            // Multiply lane cnt while the previous lane's product is added.
            prod_in = 42'(diff * $signed({1'b0, req_ff.tick_fraction}));
            if (cnt_ff != '0) begin
               res_in[lane - 2'd1] = a_ff[lane - 2'd1] + step;
            end
            cnt_in = cnt_ff + CW'(1);
            if (lane == 2'd3) begin
               rsp_in   = make_rsp(1'b1, res_in, oldest_ff);
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         filled_ff <= '0;
         wslot_ff  <= '0;
         held_ff   <= '0;
         latest_ff <= '0;
         open_ff   <= 1'b0;
         oldest_ff <= '0;
         cnt_ff    <= '0;
         pvalid_ff <= 1'b0;
         hit1_ff   <= 1'b0;
         hit2_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         filled_ff <= filled_in;
         wslot_ff  <= wslot_in;
         held_ff   <= held_in;
         latest_ff <= latest_in;
         open_ff   <= open_in;
         oldest_ff <= oldest_in;
         cnt_ff    <= cnt_in;
         pvalid_ff <= pvalid_in;
         hit1_ff   <= hit1_in;
         hit2_ff   <= hit2_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      pslot_ff <= pslot_in;
      slot1_ff <= slot1_in;
      slot2_ff <= slot2_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      res_ff   <= res_in;
      prod_ff  <= prod_in;
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = (state_ff == S_RESP);
   assign rsp_ch.data  = rsp_ff;

endmodule

>>> design/phr_ram.sv
// ----------------------------------------------------------------------------
// phr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module phr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/phr_checker.sv
// ----------------------------------------------------------------------------
// phr_checker
// Port-level checks of the position history rewind block, bound to the top.
// ----------------------------------------------------------------------------
module phr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input phr_pkg::rsp_type rsp_data
);

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // After a transaction is taken the block is busy until it has answered.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new transaction taken before the previous one answered");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready raised while a response is pending");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.out_x == 0 && rsp_data.out_y == 0 &&
                                    rsp_data.out_z == 0)
      else $error("refused transaction reported a position");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind position_history_rewind phr_checker u_phr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);
